[rtl/core/tctt_pkg.sv]
package tctt_pkg;

  localparam int DATA_W        = 32;
  localparam int CYCLES_W      = 16;
  localparam int HIT_BITS      = 3;
  localparam int NUM_TIMERS_DEF = 3;

  localparam int ENABLE_BIT = 7;
  localparam int REPEAT_BIT = 10;
  localparam logic [DATA_W-1:0] ZERO_TARGET = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          timer_index;
    logic [DATA_W-1:0]   new_mode;
    logic [DATA_W-1:0]   new_count;
    logic [DATA_W-1:0]   new_target;
    logic [CYCLES_W-1:0] advance_cycles;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [DATA_W-1:0]   read_mode;
    logic [DATA_W-1:0]   read_count;
    logic [DATA_W-1:0]   read_target;
    logic [HIT_BITS-1:0] irq_hits;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/tctt_mod.sv]
module tctt_mod (
  input  logic              clk,
  input  logic              rst,
  input  tctt_pkg::div_req_t req,
  output tctt_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(tctt_pkg::DATA_W + 1);

  logic [tctt_pkg::DATA_W-1:0] rem;
  logic [tctt_pkg::DATA_W-1:0] dvd;
  logic [tctt_pkg::DATA_W-1:0] dsr;
  logic [CNT_W-1:0]            cnt;
  logic                        done;

  logic [tctt_pkg::DATA_W:0]   trial;
  logic                        fits;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, dvd[tctt_pkg::DATA_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(tctt_pkg::DATA_W);
        rem <= '0;
        dvd <= req.dividend;
        dsr <= req.divisor;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        dvd <= dvd << 1;
        if (fits) begin
          rem <= tctt_pkg::DATA_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[tctt_pkg::DATA_W-1:0];
        end
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = cnt != '0;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

[rtl/core/three_channel_target_timer.sv]
// Bank of NUM_TIMERS timers, each with a mode word, a count and a target. Set and read
// are handled in idle, without leaving it. Advance sweeps the timers one per cycle while
// no remainder is being computed; an enabled timer in repeat mode that reaches its target
// holds the sweep while the bit-serial remainder unit sets its count to the sum modulo the
// target. A new transfer is taken in idle while the result register is empty or being
// drained. A target of zero counts as 0xFFFF.
module three_channel_target_timer #(
  parameter int NUM_TIMERS = tctt_pkg::NUM_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tctt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tctt_pkg::out_item_t out_item
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DW = tctt_pkg::DATA_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DIV
  } state_t;

  state_t state;

  logic [DW-1:0] mode_words [NUM_TIMERS];
  logic [DW-1:0] counts     [NUM_TIMERS];
  logic [DW-1:0] targets    [NUM_TIMERS];

  logic [IW-1:0]                 sweep;
  logic [tctt_pkg::CYCLES_W-1:0] cycles;
  logic [tctt_pkg::HIT_BITS-1:0] hits;

  logic [IW-1:0]                 rd_addr;
  logic [DW-1:0]                 cur_mode;
  logic [DW-1:0]                 cur_count;
  logic [DW-1:0]                 cur_target;
  logic [DW-1:0]                 adv_sum;
  logic [DW-1:0]                 eff_tgt;
  logic                          enabled;
  logic                          reach;
  logic                          idx_ok;
  logic                          last;
  logic [tctt_pkg::HIT_BITS-1:0] hit_bit;
  logic                          accept;
  logic                          result_load;
  tctt_pkg::out_item_t           result_next;

  tctt_pkg::div_req_t div_req;
  tctt_pkg::div_rsp_t div_rsp;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign idx_ok  = 32'(in_item.timer_index) < NUM_TIMERS;
  assign rd_addr = (state == ST_IDLE) ? IW'(in_item.timer_index) : sweep;

  assign cur_mode   = mode_words[rd_addr];
  assign cur_count  = counts[rd_addr];
  assign cur_target = targets[rd_addr];

  assign adv_sum = cur_count + DW'(cycles);
  assign eff_tgt = (cur_target == '0) ? tctt_pkg::ZERO_TARGET : cur_target;
  assign enabled = cur_mode[tctt_pkg::ENABLE_BIT];
  assign reach   = adv_sum >= eff_tgt;
  assign last    = sweep == IW'(NUM_TIMERS - 1);
  assign hit_bit = (enabled && reach && (32'(sweep) < tctt_pkg::HIT_BITS)) ?
                   (tctt_pkg::HIT_BITS'(1) << sweep) : '0;

  assign div_req.start    = (state == ST_SWEEP) && enabled && reach &&
                            cur_mode[tctt_pkg::REPEAT_BIT];
  assign div_req.dividend = adv_sum;
  assign div_req.divisor  = eff_tgt;

  tctt_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // result for the transfer that finishes this cycle
  always_comb begin
    result_load = 1'b0;
    result_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          result_load = 1'b1;
          case (in_item.cmd)
            tctt_pkg::CMD_SET: begin
              result_next.status = !idx_ok;
            end
            tctt_pkg::CMD_READ: begin
              if (idx_ok) begin
                result_next.read_mode   = cur_mode;
                result_next.read_count  = cur_count;
                result_next.read_target = cur_target;
              end else begin
                result_next.status = 1'b1;
              end
            end
            tctt_pkg::CMD_ADVANCE: begin
              result_load = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (!div_req.start && last) begin
          result_load          = 1'b1;
          result_next.irq_hits = hits | hit_bit;
        end
      end
      ST_DIV: begin
        if (div_rsp.done && last) begin
          result_load          = 1'b1;
          result_next.irq_hits = hits;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sweep     <= '0;
      hits      <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        mode_words[i] <= '0;
        counts[i]     <= '0;
        targets[i]    <= '0;
      end
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
        out_item  <= result_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_item.cmd)
              tctt_pkg::CMD_SET: begin
                if (idx_ok) begin
                  mode_words[rd_addr] <= in_item.new_mode;
                  counts[rd_addr]     <= in_item.new_count;
                  targets[rd_addr]    <= in_item.new_target;
                end
              end
              tctt_pkg::CMD_ADVANCE: begin
                cycles <= in_item.advance_cycles;
                hits   <= '0;
                sweep  <= '0;
                state  <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          hits <= hits | hit_bit;
          if (div_req.start) begin
            state <= ST_DIV;
          end else begin
            if (enabled) begin
              if (reach) begin
                counts[sweep]                          <= '0;
                mode_words[sweep][tctt_pkg::ENABLE_BIT] <= 1'b0;
              end else begin
                counts[sweep] <= adv_sum;
              end
            end
            if (last) begin
              state <= ST_IDLE;
            end else begin
              sweep <= sweep + 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            counts[sweep] <= div_rsp.rem;
            if (last) begin
              state <= ST_IDLE;
            end else begin
              sweep <= sweep + 1'b1;
              state <= ST_SWEEP;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_div_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> !in_ready)
    else $error("input taken while remainder unit busy");

  a_sweep_end_has_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) != ST_IDLE && !$past(rst)) |-> out_valid)
    else $error("advance finished without a result");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("remainder done outside divide state");

  a_error_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status) |->
      (out_item.read_mode == '0 && out_item.read_count == '0 &&
       out_item.read_target == '0 && out_item.irq_hits == '0))
    else $error("error result carries data");

endmodule
